// File: hw/rtl/gbrt_pkg.sv
// Package for the batch resource tracker: sizes, request codes, phases, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package gbrt_pkg;
  localparam int NumResources = 64;
  localparam int NumBatches   = 8;
  localparam int PinCapacity  = 16;
  localparam int RefBits      = 16;
  localparam logic [4:0] CapReset = 5'd16;

  typedef enum logic [3:0] {
    ReqInit     = 4'd0,
    ReqRetain   = 4'd1,
    ReqRelease  = 4'd2,
    ReqBegin    = 4'd3,
    ReqPin      = 4'd4,
    ReqCancel   = 4'd5,
    ReqSubmit   = 4'd6,
    ReqQuar     = 4'd7,
    ReqComplete = 4'd8,
    ReqDevStop  = 4'd9
  } req_e;

  typedef enum logic [1:0] {
    PhFree = 2'd0,
    PhRec  = 2'd1,
    PhSub  = 2'd2,
    PhQuar = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    StIdle, StRead, StExec, StScan, StPinWr, StDrRd, StDrCnt, StDrWr, StStat
  } state_e;
endpackage

// File: hw/rtl/gpu_batch_resource_tracker_unit.sv
// Top level of the batch resource tracker.
// Depends on gbrt_pkg.
`timescale 1ns / 1ps
// One request at a time; busy is high while it runs, and results come as one-cycle strobes
// on res_valid_o that the receiver cannot stall. After the accepting edge a simple request
// passes the Read and Exec states, and a release that fires a finalizer adds Stat. Pin scans
// the batch's pin list one memory read a cycle, then writes the new pin in PinWr. Cancel,
// complete and device-stopped on a batch with pins drain the list last to first, each pin
// taking a pin read, a count read and a write-back, then end in Stat. Busy drops between
// requests. The count and pin memories have registered reads. No clear pass: counts and
// flags keep a valid bit per entry.
module gpu_batch_resource_tracker_unit #(
  parameter int NUM_RESOURCES = gbrt_pkg::NumResources,
  parameter int NUM_BATCHES   = gbrt_pkg::NumBatches,
  parameter int PIN_CAPACITY  = gbrt_pkg::PinCapacity,
  parameter int REF_BITS      = gbrt_pkg::RefBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic [3:0]  req_type_i,
  input  logic [2:0]  batch_id_i,
  input  logic [5:0]  resource_id_i,
  input  logic [63:0] serial_i,
  input  logic        has_finalizer_i,
  output logic        res_valid_o,
  output logic        ok_o,
  output logic        finalized_o,
  output logic [5:0]  finalized_resource_o,
  output logic        last_o
);
  localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int BW = (NUM_BATCHES > 1) ? $clog2(NUM_BATCHES) : 1;
  localparam int PW = (PIN_CAPACITY > 1) ? $clog2(PIN_CAPACITY) : 1;
  localparam int CW = $clog2(PIN_CAPACITY + 1);
  localparam int AW = BW + PW;
  localparam int PinDepth = NUM_BATCHES * (1 << PW);
  localparam logic [REF_BITS-1:0] RefMax = '1;

  gbrt_pkg::state_e st_q, st_d;

  logic [REF_BITS-1:0] cnt_mem [NUM_RESOURCES];
  logic                fin_mem [NUM_RESOURCES];
  logic [NUM_RESOURCES-1:0] rvalid_q;
  logic [RW-1:0]       pin_mem [PinDepth];

  logic [1:0]          phase_q [NUM_BATCHES];
  logic [63:0]         lser_q  [NUM_BATCHES];
  logic [CW-1:0]       pcnt_q  [NUM_BATCHES];
  logic [4:0]          cap_q;

  logic [3:0]          req_q;
  logic [BW-1:0]       b_q;
  logic [RW-1:0]       r_q;
  logic [63:0]         ser_q;
  logic                hf_q, bok_q, rok_q, dup_q;
  logic [CW-1:0]       idx_q, idx_d;

  logic                cnt_we, pin_we;
  logic [RW-1:0]       cnt_addr, cnt_waddr;
  logic [REF_BITS-1:0] cnt_wdata;
  logic                fin_wdata;
  logic [REF_BITS-1:0] cnt_rd_q;
  logic                fin_rd_q, rv_rd_q;
  logic [AW-1:0]       pin_addr;
  logic [RW-1:0]       pin_rd_q;
  logic [REF_BITS-1:0] cnt_cur;
  logic [1:0]          ph;
  logic [CW-1:0]       pc;
  logic [CW-1:0]       cap_eff;
  logic                exec_ok, exec_scan, exec_drain, exec_fin;
  logic                dup_hit, pin_go;

  assign busy        = (st_q != gbrt_pkg::StIdle);
  assign cfg_ready_o = ~busy;
  assign cnt_cur     = rv_rd_q ? cnt_rd_q : '0;
  assign ph          = phase_q[b_q];
  assign pc          = pcnt_q[b_q];
  assign cap_eff     = (32'(cap_q) > PIN_CAPACITY) ? CW'(PIN_CAPACITY) : CW'(cap_q);

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
      fin_mem[cnt_waddr] <= fin_wdata;
    end
    cnt_rd_q <= cnt_mem[cnt_addr];
    fin_rd_q <= fin_mem[cnt_addr];
    if (pin_we) pin_mem[pin_addr] <= r_q;
    pin_rd_q <= pin_mem[pin_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= '0;
      rv_rd_q  <= 1'b0;
    end else begin
      if (cnt_we) rvalid_q[cnt_waddr] <= 1'b1;
      rv_rd_q <= rvalid_q[cnt_addr];
    end
  end

  always_comb begin
    exec_ok = 1'b0;
    unique case (req_q)
      gbrt_pkg::ReqInit:     exec_ok = rok_q;
      gbrt_pkg::ReqRetain:   exec_ok = rok_q && cnt_cur != '0 && cnt_cur != RefMax;
      gbrt_pkg::ReqRelease:  exec_ok = rok_q && cnt_cur != '0;
      gbrt_pkg::ReqBegin:
        exec_ok = bok_q && ph == gbrt_pkg::PhFree && ser_q != '0 && ser_q > lser_q[b_q];
      gbrt_pkg::ReqPin:      exec_ok = bok_q && rok_q && ph == gbrt_pkg::PhRec;
      gbrt_pkg::ReqCancel:   exec_ok = bok_q && ph == gbrt_pkg::PhRec;
      gbrt_pkg::ReqSubmit:   exec_ok = bok_q && ph == gbrt_pkg::PhRec;
      gbrt_pkg::ReqQuar:     exec_ok = bok_q && ph == gbrt_pkg::PhSub;
      gbrt_pkg::ReqComplete: exec_ok = bok_q && ph == gbrt_pkg::PhSub && lser_q[b_q] == ser_q;
      gbrt_pkg::ReqDevStop:  exec_ok = bok_q && ph[1] && lser_q[b_q] == ser_q;
      default:               exec_ok = 1'b0;
    endcase
  end

  assign exec_scan  = exec_ok && req_q == gbrt_pkg::ReqPin;
  assign exec_drain = exec_ok && pc != '0 &&
                      (req_q == gbrt_pkg::ReqCancel || req_q == gbrt_pkg::ReqComplete ||
                       req_q == gbrt_pkg::ReqDevStop);
  assign exec_fin   = exec_ok && req_q == gbrt_pkg::ReqRelease &&
                      cnt_cur == REF_BITS'(1) && fin_rd_q;
  assign dup_hit    = (st_q == gbrt_pkg::StScan) && (idx_q != '0) && (pin_rd_q == r_q);
  assign pin_go     = !dup_q && (pc < cap_eff) && cnt_cur != '0 && cnt_cur != RefMax;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      gbrt_pkg::StIdle:  if (start) st_d = gbrt_pkg::StRead;
      gbrt_pkg::StRead:  st_d = gbrt_pkg::StExec;
      gbrt_pkg::StExec: begin
        if (exec_scan) st_d = gbrt_pkg::StScan;
        else if (exec_drain) st_d = gbrt_pkg::StDrRd;
        else if (exec_fin) st_d = gbrt_pkg::StStat;
        else st_d = gbrt_pkg::StIdle;
      end
      gbrt_pkg::StScan:  if (idx_q >= pc) st_d = gbrt_pkg::StPinWr;
      gbrt_pkg::StPinWr: st_d = gbrt_pkg::StIdle;
      gbrt_pkg::StDrRd:  st_d = gbrt_pkg::StDrCnt;
      gbrt_pkg::StDrCnt: st_d = gbrt_pkg::StDrWr;
      gbrt_pkg::StDrWr:  st_d = (idx_q == '0) ? gbrt_pkg::StStat : gbrt_pkg::StDrRd;
      gbrt_pkg::StStat:  st_d = gbrt_pkg::StIdle;
      default:           st_d = gbrt_pkg::StIdle;
    endcase
  end

  always_comb begin
    cnt_addr  = r_q;
    cnt_waddr = r_q;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_cur;
    fin_wdata = fin_rd_q;
    pin_we    = 1'b0;
    pin_addr  = {b_q, idx_q[PW-1:0]};
    idx_d     = idx_q;
    res_valid_o = 1'b0;
    ok_o = 1'b0; finalized_o = 1'b0; finalized_resource_o = '0; last_o = 1'b0;
    unique case (st_q)
      gbrt_pkg::StIdle: cnt_addr = RW'(resource_id_i);
      gbrt_pkg::StExec: begin
        idx_d = exec_drain ? pc : '0;
        if (!exec_scan && !exec_drain) begin
          res_valid_o = 1'b1;
          ok_o = exec_ok;
          finalized_o = exec_fin;
          finalized_resource_o = exec_fin ? 6'(r_q) : '0;
          last_o = !exec_fin;
        end
        unique case (req_q)
          gbrt_pkg::ReqInit: begin
            cnt_we = exec_ok; cnt_wdata = REF_BITS'(1); fin_wdata = hf_q;
          end
          gbrt_pkg::ReqRetain: begin
            cnt_we = exec_ok; cnt_wdata = cnt_cur + REF_BITS'(1);
          end
          gbrt_pkg::ReqRelease: begin
            cnt_we = exec_ok; cnt_wdata = cnt_cur - REF_BITS'(1);
          end
          default: ;
        endcase
      end
      gbrt_pkg::StScan: idx_d = idx_q + CW'(1);
      gbrt_pkg::StPinWr: begin
        res_valid_o = 1'b1; last_o = 1'b1;
        ok_o = dup_q || pin_go;
        cnt_we = pin_go; cnt_wdata = cnt_cur + REF_BITS'(1);
        pin_we = pin_go;
        pin_addr = {b_q, pc[PW-1:0]};
      end
      gbrt_pkg::StDrRd: begin
        idx_d = idx_q - CW'(1);
        pin_addr = {b_q, idx_d[PW-1:0]};
      end
      gbrt_pkg::StDrCnt: cnt_addr = pin_rd_q;
      gbrt_pkg::StDrWr: begin
        cnt_waddr = pin_rd_q;
        cnt_we = cnt_cur != '0;
        cnt_wdata = cnt_cur - REF_BITS'(1);
        if (cnt_cur == REF_BITS'(1) && fin_rd_q) begin
          res_valid_o = 1'b1; ok_o = 1'b1; finalized_o = 1'b1;
          finalized_resource_o = 6'(pin_rd_q);
        end
      end
      gbrt_pkg::StStat: begin
        res_valid_o = 1'b1; ok_o = 1'b1; last_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= gbrt_pkg::StIdle;
      cap_q <= gbrt_pkg::CapReset;
      for (int i = 0; i < NUM_BATCHES; i++) begin
        phase_q[i] <= gbrt_pkg::PhFree;
        lser_q[i]  <= '0;
        pcnt_q[i]  <= '0;
      end
      idx_q <= '0; dup_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
      dup_q <= (st_q == gbrt_pkg::StScan) && (dup_q || dup_hit);
      if (st_q == gbrt_pkg::StExec && exec_ok) begin
        unique case (req_q)
          gbrt_pkg::ReqBegin: begin
            lser_q[b_q] <= ser_q; phase_q[b_q] <= gbrt_pkg::PhRec;
          end
          gbrt_pkg::ReqSubmit:   phase_q[b_q] <= gbrt_pkg::PhSub;
          gbrt_pkg::ReqQuar:     phase_q[b_q] <= gbrt_pkg::PhQuar;
          gbrt_pkg::ReqCancel:   phase_q[b_q] <= gbrt_pkg::PhFree;
          gbrt_pkg::ReqComplete: phase_q[b_q] <= gbrt_pkg::PhFree;
          gbrt_pkg::ReqDevStop:  phase_q[b_q] <= gbrt_pkg::PhFree;
          default: ;
        endcase
      end
      if (st_q == gbrt_pkg::StPinWr && pin_go) pcnt_q[b_q] <= pc + CW'(1);
      else if (st_q == gbrt_pkg::StDrRd) pcnt_q[b_q] <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == gbrt_pkg::StIdle && start) begin
      req_q <= req_type_i;
      b_q   <= BW'(batch_id_i);
      r_q   <= RW'(resource_id_i);
      ser_q <= serial_i;
      hf_q  <= has_finalizer_i;
      bok_q <= 32'(batch_id_i) < NUM_BATCHES;
      rok_q <= 32'(resource_id_i) < NUM_RESOURCES;
    end
  end
endmodule

// File: hw/rtl/gbrt_checker.sv
// Port checker for the batch resource tracker.
// Depends on gpu_batch_resource_tracker_unit ports.
`timescale 1ns / 1ps
module gbrt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic cfg_ready_o,
  input logic res_valid_o,
  input logic finalized_o,
  input logic last_o,
  input logic ok_o
);
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && finalized_o |-> ok_o && !last_o) else $error("bad finalize item");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy) else $error("cfg while busy");
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !res_valid_o) else $error("result while idle");
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |=> !busy) else $error("busy after last item");
endmodule

bind gpu_batch_resource_tracker_unit gbrt_checker u_chk (.*);

// File: dv/tb_gpu_batch_resource_tracker_unit.sv
// Testbench for gpu_batch_resource_tracker_unit: directed and random requests, each checked
// against an in-bench predictor of counts, batch phases and pin lists. Depends on gbrt_pkg.
`timescale 1ns / 1ps
module tb_gpu_batch_resource_tracker_unit;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 40;

  typedef struct packed {
    logic       ok;
    logic       fin;
    logic [5:0] res;
    logic       last;
  } status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;
  logic [3:0]  req_type_i;
  logic [2:0]  batch_id_i;
  logic [5:0]  resource_id_i;
  logic [63:0] serial_i;
  logic        has_finalizer_i;
  logic        res_valid_o;
  logic        ok_o;
  logic        finalized_o;
  logic [5:0]  finalized_resource_o;
  logic        last_o;

  gpu_batch_resource_tracker_unit DUT (.*);

  logic [gbrt_pkg::RefBits-1:0] ref_cnt [gbrt_pkg::NumResources];
  logic               fin_flag [gbrt_pkg::NumResources];
  gbrt_pkg::phase_e   phase [gbrt_pkg::NumBatches];
  logic [63:0]        last_ser [gbrt_pkg::NumBatches];
  int unsigned        pins [gbrt_pkg::NumBatches];
  logic [5:0]         pin_list [gbrt_pkg::NumBatches][gbrt_pkg::PinCapacity];
  logic [4:0]         cap;
  status_t            status_q[$];
  int                 errors = 0;
  int                 cycles = 0;
  bit                 no_gap;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_gpu_batch_resource_tracker_unit failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && res_valid_o) begin
      if (status_q.size() == 0) begin
        report("result with none expected");
      end else begin
        want = status_q.pop_front();
        if (ok_o !== want.ok) report($sformatf("ok %b want %b", ok_o, want.ok));
        if (finalized_o !== want.fin)
          report($sformatf("finalized %b want %b", finalized_o, want.fin));
        if (finalized_resource_o !== want.res)
          report($sformatf("resource %0d want %0d", finalized_resource_o, want.res));
        if (last_o !== want.last) report($sformatf("last %b want %b", last_o, want.last));
      end
    end
  end

  function automatic bit take_ref(input logic [5:0] r);
    if (ref_cnt[r] == '0 || ref_cnt[r] == '1) return 1'b0;
    ref_cnt[r] = ref_cnt[r] + 1'b1;
    return 1'b1;
  endfunction

  task automatic drop_ref(input logic [5:0] r, output bit done);
    done = 1'b0;
    if (ref_cnt[r] != '0) begin
      ref_cnt[r] = ref_cnt[r] - 1'b1;
      if (ref_cnt[r] == '0 && fin_flag[r]) status_q.push_back({1'b1, 1'b1, r, 1'b0});
      done = 1'b1;
    end
  endtask

  task automatic drain_pins(input logic [2:0] b);
    bit dummy;
    while (pins[b] > 0) begin
      pins[b]--;
      drop_ref(pin_list[b][pins[b]], dummy);
    end
    phase[b] = gbrt_pkg::PhFree;
  endtask

  task automatic predict_request(input logic [3:0] rq, input logic [2:0] b,
                                 input logic [5:0] r, input logic [63:0] s, input logic f);
    bit okv;
    bit dup;
    int unsigned lim;
    okv = 1'b0;
    case (rq)
      gbrt_pkg::ReqInit: begin
        ref_cnt[r] = 1;
        fin_flag[r] = f;
        okv = 1'b1;
      end
      gbrt_pkg::ReqRetain: okv = take_ref(r);
      gbrt_pkg::ReqRelease: drop_ref(r, okv);
      gbrt_pkg::ReqBegin: begin
        if (phase[b] == gbrt_pkg::PhFree && s != 0 && s > last_ser[b]) begin
          last_ser[b] = s;
          phase[b] = gbrt_pkg::PhRec;
          okv = 1'b1;
        end
      end
      gbrt_pkg::ReqPin: begin
        if (phase[b] == gbrt_pkg::PhRec) begin
          lim = (cap > gbrt_pkg::PinCapacity) ? gbrt_pkg::PinCapacity : cap;
          dup = 1'b0;
          for (int i = 0; i < pins[b]; i++) if (pin_list[b][i] == r) dup = 1'b1;
          if (dup) begin
            okv = 1'b1;
          end else if (pins[b] < lim && take_ref(r)) begin
            pin_list[b][pins[b]] = r;
            pins[b]++;
            okv = 1'b1;
          end
        end
      end
      gbrt_pkg::ReqCancel: begin
        if (phase[b] == gbrt_pkg::PhRec) begin
          drain_pins(b);
          okv = 1'b1;
        end
      end
      gbrt_pkg::ReqSubmit: begin
        if (phase[b] == gbrt_pkg::PhRec) begin
          phase[b] = gbrt_pkg::PhSub;
          okv = 1'b1;
        end
      end
      gbrt_pkg::ReqQuar: begin
        if (phase[b] == gbrt_pkg::PhSub) begin
          phase[b] = gbrt_pkg::PhQuar;
          okv = 1'b1;
        end
      end
      gbrt_pkg::ReqComplete: begin
        if (phase[b] == gbrt_pkg::PhSub && last_ser[b] == s) begin
          drain_pins(b);
          okv = 1'b1;
        end
      end
      gbrt_pkg::ReqDevStop: begin
        if ((phase[b] == gbrt_pkg::PhSub || phase[b] == gbrt_pkg::PhQuar) &&
            last_ser[b] == s) begin
          drain_pins(b);
          okv = 1'b1;
        end
      end
      default: ;
    endcase
    status_q.push_back({okv, 1'b0, 6'd0, 1'b1});
  endtask

  task automatic send_req(input logic [3:0] rq, input logic [2:0] b, input logic [5:0] r,
                          input logic [63:0] s, input logic f);
    if (!no_gap && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_type_i <= rq;
    batch_id_i <= b;
    resource_id_i <= r;
    serial_i <= s;
    has_finalizer_i <= f;
    do @(posedge clk_i); while (busy);
    predict_request(rq, b, r, s, f);
  endtask

  task automatic hold_until_idle();
    start <= 1'b0;
    while (status_q.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [4:0] v);
    hold_until_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_resource_ops();
    send_req(gbrt_pkg::ReqInit, 0, 63, '0, 1'b1);
    send_req(gbrt_pkg::ReqRetain, 0, 63, '0, 1'b0);
    send_req(gbrt_pkg::ReqRelease, 0, 63, '0, 1'b0);
    send_req(gbrt_pkg::ReqRelease, 0, 63, '0, 1'b0);
    send_req(gbrt_pkg::ReqRelease, 0, 63, '0, 1'b0);
    send_req(gbrt_pkg::ReqRetain, 0, 63, '0, 1'b0);
    send_req(4'd15, 7, 63, '1, 1'b1);
    send_req(4'd10, 0, 0, '0, 1'b0);
    hold_until_idle();
  endtask

  task automatic test_batch_flow();
    for (int i = 0; i < 4; i++) send_req(gbrt_pkg::ReqInit, 0, 6'(i), '0, i[0]);
    send_req(gbrt_pkg::ReqBegin, 1, 0, '0, 1'b0);
    send_req(gbrt_pkg::ReqBegin, 1, 0, 64'd5, 1'b0);
    send_req(gbrt_pkg::ReqBegin, 1, 0, 64'd6, 1'b0);
    for (int i = 0; i < 4; i++) send_req(gbrt_pkg::ReqPin, 1, 6'(i), '0, 1'b0);
    send_req(gbrt_pkg::ReqPin, 1, 2, '0, 1'b0);
    send_req(gbrt_pkg::ReqSubmit, 1, 0, '0, 1'b0);
    send_req(gbrt_pkg::ReqComplete, 1, 0, 64'd4, 1'b0);
    send_req(gbrt_pkg::ReqQuar, 1, 0, '0, 1'b0);
    send_req(gbrt_pkg::ReqDevStop, 1, 0, 64'd5, 1'b0);
    send_req(gbrt_pkg::ReqBegin, 7, 0, '1, 1'b0);
    send_req(gbrt_pkg::ReqPin, 7, 0, '0, 1'b0);
    send_req(gbrt_pkg::ReqCancel, 7, 0, '0, 1'b0);
    send_req(gbrt_pkg::ReqBegin, 7, 0, '1, 1'b0);
    hold_until_idle();
  endtask

  task automatic test_capacity();
    write_cap(5'd0);
    send_req(gbrt_pkg::ReqInit, 0, 10, '0, 1'b1);
    send_req(gbrt_pkg::ReqBegin, 2, 0, 64'd1, 1'b0);
    send_req(gbrt_pkg::ReqPin, 2, 10, '0, 1'b0);
    write_cap(5'd31);
    for (int i = 0; i < 17; i++) send_req(gbrt_pkg::ReqInit, 0, 6'(20 + i), '0, 1'b1);
    for (int i = 0; i < 17; i++) send_req(gbrt_pkg::ReqPin, 2, 6'(20 + i), '0, 1'b0);
    write_cap(5'd1);
    send_req(gbrt_pkg::ReqPin, 2, 10, '0, 1'b0);
    send_req(gbrt_pkg::ReqPin, 2, 20, '0, 1'b0);
    send_req(gbrt_pkg::ReqSubmit, 2, 0, '0, 1'b0);
    for (int i = 0; i < 8; i++) send_req(gbrt_pkg::ReqRelease, 0, 6'(20 + i), '0, 1'b0);
    send_req(gbrt_pkg::ReqComplete, 2, 0, 64'd1, 1'b0);
    write_cap(5'd16);
  endtask

  task automatic test_dead_resource();
    no_gap = 1'b1;
    send_req(gbrt_pkg::ReqBegin, 3, 0, 64'd9, 1'b0);
    send_req(gbrt_pkg::ReqPin, 3, 50, '0, 1'b0);
    send_req(gbrt_pkg::ReqRetain, 0, 50, '0, 1'b0);
    send_req(gbrt_pkg::ReqInit, 0, 50, '0, 1'b1);
    send_req(gbrt_pkg::ReqPin, 3, 50, '0, 1'b0);
    send_req(gbrt_pkg::ReqRelease, 0, 50, '0, 1'b0);
    send_req(gbrt_pkg::ReqCancel, 3, 0, '0, 1'b0);
    send_req(gbrt_pkg::ReqRelease, 0, 50, '0, 1'b0);
    no_gap = 1'b0;
    hold_until_idle();
  endtask

  task automatic random_item();
    logic [2:0]  b;
    logic [5:0]  r;
    logic [3:0]  rq;
    logic [63:0] s;
    int          sel;
    b = 3'($urandom_range(7));
    r = ($urandom_range(99) < 80) ? 6'($urandom_range(15)) : 6'($urandom_range(63));
    s = {$urandom, $urandom};
    sel = $urandom_range(99);
    case ($urandom_range(2))
      0: rq = gbrt_pkg::ReqInit;
      1: rq = gbrt_pkg::ReqRetain;
      default: rq = gbrt_pkg::ReqRelease;
    endcase
    if (sel < 4) begin
      rq = 4'($urandom_range(10, 15));
    end else begin
      case (phase[b])
        gbrt_pkg::PhFree: if (sel < 70) begin
          rq = gbrt_pkg::ReqBegin;
          if ($urandom_range(99) >= 3) s = last_ser[b] + 64'($urandom_range(1, 3));
        end
        gbrt_pkg::PhRec: begin
          if (sel < 60) rq = gbrt_pkg::ReqPin;
          else if (sel < 68) rq = gbrt_pkg::ReqCancel;
          else if (sel < 82) rq = gbrt_pkg::ReqSubmit;
        end
        gbrt_pkg::PhSub: begin
          if (sel < 40) rq = gbrt_pkg::ReqComplete;
          else if (sel < 60) rq = gbrt_pkg::ReqQuar;
          else if (sel < 80) rq = gbrt_pkg::ReqDevStop;
          if ($urandom_range(99) >= 10) s = last_ser[b];
        end
        default: begin
          if (sel < 60) rq = gbrt_pkg::ReqDevStop;
          if ($urandom_range(99) >= 10) s = last_ser[b];
        end
      endcase
    end
    send_req(rq, b, r, s, 1'($urandom_range(1)));
  endtask

  task automatic test_random();
    for (int i = 0; i < 135; i++) random_item();
    write_cap(5'($urandom_range(1, 4)));
    no_gap = 1'b1;
    for (int i = 0; i < 135; i++) random_item();
    no_gap = 1'b0;
    write_cap(5'd16);
    for (int i = 0; i < 135; i++) random_item();
  endtask

  initial begin
    start = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    req_type_i = '0;
    batch_id_i = '0;
    resource_id_i = '0;
    serial_i = '0;
    has_finalizer_i = 1'b0;
    no_gap = 1'b0;
    cap = gbrt_pkg::CapReset;
    for (int i = 0; i < gbrt_pkg::NumResources; i++) begin
      ref_cnt[i] = '0;
      fin_flag[i] = 1'b0;
    end
    for (int i = 0; i < gbrt_pkg::NumBatches; i++) begin
      phase[i] = gbrt_pkg::PhFree;
      last_ser[i] = '0;
      pins[i] = 0;
    end
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_resource_ops();
    test_batch_flow();
    test_capacity();
    test_dead_resource();
    test_random();
    hold_until_idle();
    if (errors == 0) begin
      $display("tb_gpu_batch_resource_tracker_unit passed");
    end else begin
      $display("tb_gpu_batch_resource_tracker_unit failed");
    end
    $finish;
  end
endmodule
